[src/kmp_pkg.sv]
// Package for the KMP stream matcher: action codes, status codes,
// sequencer state type and fixed field widths. No dependencies.
package kmp_pkg;

	localparam int ACTION_W = 2;
	localparam int BYTE_W   = 8;
	localparam int POS_W    = 32;

	typedef enum logic [ACTION_W-1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_TEXT   = 2'd2
	} action_t;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_DROPPED = 1'b1;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_WORK = 1'b1
	} seq_state_t;

endpackage

[src/kmp_stream_if.sv]
// Channel interfaces of the KMP stream matcher: command items in,
// result items out. Depends on kmp_pkg for field widths.
interface kmp_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [kmp_pkg::ACTION_W-1:0]  action;
	logic [kmp_pkg::BYTE_W-1:0]    data_byte;

	modport source (output valid, action, data_byte, input ready);
	modport sink   (input valid, action, data_byte, output ready);
endinterface

interface kmp_res_if;
	logic                          valid;
	logic                          ready;
	logic                          match_found;
	logic [kmp_pkg::POS_W-1:0]     match_start;
	logic                          status;

	modport source (output valid, match_found, match_start, status, input ready);
	modport sink   (input valid, match_found, match_start, status, output ready);
endinterface

[src/kmp_stream_matcher_core.sv]
// Top level of the KMP stream matcher: pattern and failure memories, the
// failure-chain sequencer and the result register.
// Depends on kmp_pkg and the interfaces in kmp_stream_if.sv.

// Knuth-Morris-Pratt matcher on a byte stream. Each command item is one of:
// clear (empty the pattern, restart the text position), append a pattern byte
// (its failure entry is built at once), or feed a text byte (a hit reports the
// 32-bit position of the occurrence's first byte; overlapping hits are found).
// Every item yields exactly one result item. Pattern bytes and failure entries
// live in two synchronous memories of MAX_PATTERN entries, each with a write
// port and a registered read port; they need no clearing after reset, as only
// entries below the pattern length are ever used. After acceptance an item
// stays in the work state through its failure-chain steps (each step is one
// memory read round trip) until the result register is free, then loads its
// result; the next item is taken only after that, and the chain steps
// amortise to about one per text byte. The result register lets the next item
// start while an earlier result still waits to be taken. A pattern byte
// offered when the store is full is dropped and flagged with status 1.
module kmp_stream_matcher_core #(
	parameter int MAX_PATTERN = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	kmp_cmd_if.sink          cmd,
	kmp_res_if.source        res
);

	localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int CW = $clog2(MAX_PATTERN + 1);
	localparam int BW = kmp_pkg::BYTE_W;
	localparam int PW = kmp_pkg::POS_W;

	// Memories: no reset, each entry written before its read data is ever used.
	logic [BW-1:0] pat_mem [MAX_PATTERN];
	logic [AW-1:0] fail_mem [MAX_PATTERN];

	// Control state.
	kmp_pkg::seq_state_t state_q, state_d;
	logic [CW-1:0] pattern_count_q;
	logic [AW-1:0] build_prefix_len_q;
	logic [AW-1:0] matched_len_q;
	logic [PW-1:0] text_position_q;
	logic          out_valid_q;

	// Item latch, chain index, memory read data, result payload.
	logic [kmp_pkg::ACTION_W-1:0] act_q;
	logic [BW-1:0] byte_q;
	logic [AW-1:0] k_q, k_d;
	logic [BW-1:0] pat_rd_q;
	logic [AW-1:0] fail_rd_q;
	logic          out_found_q;
	logic [PW-1:0] out_start_q;
	logic          out_status_q;

	// Sequencer signals.
	logic          cmd_acc;
	logic          slot_free;
	logic          is_full;
	logic          count_zero;
	logic          chain_op;
	logic          byte_eq;
	logic          step;
	logic          done;
	logic          finish;
	logic [CW-1:0] k_inc;
	logic [AW-1:0] fail_addr;

	// Next values decided at finish.
	logic          found_d;
	logic [PW-1:0] start_d;
	logic          status_d;
	logic          pat_we;
	logic [AW-1:0] new_prefix;

	assign cmd_acc    = cmd.valid && cmd.ready;
	assign slot_free  = !out_valid_q || res.ready;
	assign is_full    = (pattern_count_q == CW'(MAX_PATTERN));
	assign count_zero = (pattern_count_q == '0);
	assign byte_eq    = (pat_rd_q == byte_q);
	assign k_inc      = CW'(k_q) + CW'(byte_eq);

	// Items that walk the failure chain: text with a pattern, or an append
	// to a non-empty, non-full pattern.
	always_comb begin
		case (act_q)
			kmp_pkg::ACT_APPEND: chain_op = !count_zero && !is_full;
			kmp_pkg::ACT_TEXT:   chain_op = !count_zero;
			default:             chain_op = 1'b0;
		endcase
	end

	// Take one chain step on a mismatch with a non-zero index.
	assign step   = (state_q == kmp_pkg::ST_WORK) && chain_op && (k_q != '0) && !byte_eq;
	assign done   = (state_q == kmp_pkg::ST_WORK) && !step;
	assign finish = done && slot_free;

	// Chain index: seed on acceptance, follow the failure entry on a step,
	// hold otherwise so the read data stays put while the result waits.
	always_comb begin
		if (cmd_acc) begin
			k_d = (cmd.action == kmp_pkg::ACT_TEXT) ? matched_len_q : build_prefix_len_q;
		end else if (step) begin
			k_d = fail_rd_q;
		end else begin
			k_d = k_q;
		end
	end

	assign fail_addr = (k_d == '0) ? '0 : k_d - AW'(1);

	// New failure entry for an appended byte.
	assign new_prefix = count_zero ? '0 : k_inc[AW-1:0];

	// Result of the item being finished.
	always_comb begin
		found_d  = 1'b0;
		start_d  = '0;
		status_d = kmp_pkg::STATUS_OK;
		pat_we   = 1'b0;
		case (act_q)
			kmp_pkg::ACT_APPEND: begin
				if (is_full) begin
					status_d = kmp_pkg::STATUS_DROPPED;
				end else begin
					pat_we = finish;
				end
			end
			kmp_pkg::ACT_TEXT: begin
				if (!count_zero && (k_inc == pattern_count_q)) begin
					found_d = 1'b1;
					start_d = text_position_q - PW'(pattern_count_q) + PW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer: next state.
	always_comb begin
		case (state_q)
			kmp_pkg::ST_IDLE: state_d = cmd_acc ? kmp_pkg::ST_WORK : kmp_pkg::ST_IDLE;
			kmp_pkg::ST_WORK: state_d = finish ? kmp_pkg::ST_IDLE : kmp_pkg::ST_WORK;
			default:          state_d = kmp_pkg::ST_IDLE;
		endcase
	end

	// Sequencer: outputs.
	always_comb begin
		case (state_q)
			kmp_pkg::ST_IDLE: cmd.ready = 1'b1;
			kmp_pkg::ST_WORK: cmd.ready = 1'b0;
			default:          cmd.ready = 1'b0;
		endcase
	end

	// Memories: write the appended byte and its failure entry at the pattern
	// end, read at the chain index (failure memory one below it) every cycle.
	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[pattern_count_q[AW-1:0]]  <= byte_q;
			fail_mem[pattern_count_q[AW-1:0]] <= new_prefix;
		end
		pat_rd_q  <= pat_mem[k_d];
		fail_rd_q <= fail_mem[fail_addr];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= kmp_pkg::ST_IDLE;
			pattern_count_q    <= '0;
			build_prefix_len_q <= '0;
			matched_len_q      <= '0;
			text_position_q    <= '0;
			out_valid_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (finish) begin
				case (act_q)
					kmp_pkg::ACT_CLEAR: begin
						pattern_count_q    <= '0;
						build_prefix_len_q <= '0;
						matched_len_q      <= '0;
						text_position_q    <= '0;
					end
					kmp_pkg::ACT_APPEND: begin
						if (!is_full) begin
							build_prefix_len_q <= new_prefix;
							pattern_count_q    <= pattern_count_q + CW'(1);
						end
					end
					kmp_pkg::ACT_TEXT: begin
						if (!count_zero) begin
							// On a hit, restart from the last failure entry.
							matched_len_q <= found_d ? build_prefix_len_q : k_inc[AW-1:0];
						end
						text_position_q <= text_position_q + PW'(1);
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Payload registers: item latch, chain index, result.
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			act_q  <= cmd.action;
			byte_q <= cmd.data_byte;
		end
		k_q <= k_d;
		if (finish) begin
			out_found_q  <= found_d;
			out_start_q  <= start_d;
			out_status_q <= status_d;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.match_found = out_found_q;
	assign res.match_start = out_start_q;
	assign res.status      = out_status_q;

	// The matched length stays below the pattern length.
	a_matched_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_zero ? (matched_len_q == '0) : (CW'(matched_len_q) < pattern_count_q))
		else $error("matched length not below pattern length");

	// The last failure entry stays below the pattern length.
	a_prefix_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_zero ? (build_prefix_len_q == '0)
		           : (CW'(build_prefix_len_q) < pattern_count_q))
		else $error("build prefix length not below pattern length");

	// The store never holds more than its depth.
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pattern_count_q <= CW'(MAX_PATTERN))
		else $error("pattern count beyond store depth");

	// Every failure-chain step shortens the index, so the walk ends.
	a_chain_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (k_q < $past(k_q)))
		else $error("failure chain step did not shorten the index");

	// A result is loaded only while no earlier result is left waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> (!out_valid_q || res.ready))
		else $error("result register overwritten");

endmodule
